>>> rtl/ptnq_pkg.sv
// ptnq_pkg: shared constants, types and codes of the point table nearest query core.
// Used by ptnq_cell, ptnq_dist and point_table_nearest_query_core; no dependencies.
`timescale 1ns / 1ps

package ptnq_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = 14;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;

    localparam logic [COORD_W-1:0] COORD_MAX = 14'd9999;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LIST   = 2'd2,
        REQ_QUERY  = 2'd3
    } req_e;

    typedef enum logic [3:0] {
        ST_INVALID = 4'd0,
        ST_EXISTS  = 4'd1,
        ST_ADDED   = 4'd2,
        ST_FULL    = 4'd3,
        ST_REMOVED = 4'd4,
        ST_ABSENT  = 4'd5,
        ST_LISTED  = 4'd6,
        ST_NONE    = 4'd7,
        ST_NEAREST = 4'd8
    } status_e;

    // Broadcast controls for the row of cells.
    typedef struct packed {
        logic   rotate;
        logic   shift;
        logic   write;
        point_t key;
    } cell_ctl_t;

    // Output of the distance pipeline.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sq_dist;
        point_t            pt;
    } dist_res_t;

endpackage

>>> rtl/ptnq_cell.sv
// ptnq_cell: one slot of the point table; loads from its neighbor or takes a written point.
// Depends on ptnq_pkg.
`timescale 1ns / 1ps

module ptnq_cell
    import ptnq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      sel_shift,
    input  logic      sel_write,
    input  point_t    nbr_point,
    output point_t    point
);

    point_t point_reg;
    point_t point_next;

    always_comb
    begin
        point_next = point_reg;
        if (ctl.rotate || (ctl.shift && sel_shift))
        begin
            point_next = nbr_point;
        end
        else if (ctl.write && sel_write)
        begin
            point_next = ctl.key;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign point = point_reg;

endmodule

>>> rtl/ptnq_dist.sv
// ptnq_dist: three-stage squared distance pipeline (abs diff, squares, sum).
// Depends on ptnq_pkg.
`timescale 1ns / 1ps

module ptnq_dist
    import ptnq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  point_t             in_pt,
    input  logic [COORD_W-1:0] qx,
    input  logic [COORD_W-1:0] qy,
    output dist_res_t          res,
    output logic               busy
);

    logic               v1_reg, v2_reg, v3_reg;
    logic               v1_next, v2_next, v3_next;
    logic [COORD_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    point_t             pt1_reg, pt2_reg, pt3_reg;

    always_comb
    begin
        v1_next   = in_valid;
        v2_next   = v1_reg;
        v3_next   = v2_reg;
        dx_next   = (in_pt.x > qx) ? in_pt.x - qx : qx - in_pt.x;
        dy_next   = (in_pt.y > qy) ? in_pt.y - qy : qy - in_pt.y;
        sqx_next  = {{COORD_W{1'b0}}, dx_reg} * {{COORD_W{1'b0}}, dx_reg};
        sqy_next  = {{COORD_W{1'b0}}, dy_reg} * {{COORD_W{1'b0}}, dy_reg};
        dist_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        pt1_reg  <= in_pt;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        pt2_reg  <= pt1_reg;
        dist_reg <= dist_next;
        pt3_reg  <= pt2_reg;
    end

    assign res.valid   = v3_reg;
    assign res.sq_dist = dist_reg;
    assign res.pt      = pt3_reg;
    assign busy        = v1_reg | v2_reg | v3_reg;

endmodule

>>> rtl/point_table_nearest_query_core.sv
// point_table_nearest_query_core: top level, control sequencer and row of table cells.
// Depends on ptnq_pkg, ptnq_cell and ptnq_dist.
//
// The block holds up to TABLE_DEPTH (32) points in a ring of cells and serves one request
// at a time: add, remove, list, or nearest query. Every well-formed request rotates the
// whole ring once, one cell per cycle while the rotation is not stalled, so the entry at
// cell 0 walks through the table in order and the ring ends where it started; add and
// remove then write or close the gap in the finish step. Without output stalls an add, a
// remove or a list of an empty table places its result after the full rotation, the
// finish step and the response step. A nearest query also waits in the finish step for
// the three-stage distance pipeline to drain. A list of a nonempty table streams its
// items during the rotation and ends with the finish step, with no response step. A
// request with out-of-range coordinates goes straight from acceptance to the response
// step. A list stalls the rotation whenever an entry sits at the head and the output
// register is full, so its length also depends on out_ready.
// A new request is taken as soon as the sequencer is back in idle, even if the last result
// item has not been taken from the output register yet; in_ready comes from the state
// register, so it rises in the cycle after the response step places that item.
`timescale 1ns / 1ps

module point_table_nearest_query_core
    import ptnq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [COORD_W-1:0] coord_x,
    input  logic [COORD_W-1:0] coord_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         status,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic               last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_RESP = 4'b1000
    } fsm_e;

    // control state
    fsm_e             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             found_reg, found_next;
    logic             qfound_reg, qfound_next;
    logic             out_valid_reg, out_valid_next;

    // request and result payload
    req_e               req_reg, req_next;
    logic [COORD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [IDX_W-1:0]   at_reg, at_next;
    logic [DIST_W-1:0]  best_d_reg, best_d_next;
    point_t             best_pt_reg, best_pt_next;
    status_e            resp_st_reg, resp_st_next;
    point_t             resp_pt_reg, resp_pt_next;
    status_e            out_st_reg, out_st_next;
    point_t             out_pt_reg, out_pt_next;
    logic               out_last_reg, out_last_next;

    point_t    cells [TABLE_DEPTH];
    cell_ctl_t ctl;
    dist_res_t dres;
    logic      dist_busy;
    logic      dist_in_valid;

    logic   accept, out_free, step, k_in, fin_go, coord_bad;
    point_t head;
    point_t key;

    assign head     = cells[0];
    assign key      = '{y: qy_reg, x: qx_reg};
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign k_in     = (CNT_W'(k_reg) < count_reg);
    // list waits for a free output slot only while a real entry sits at the head
    assign step     = (state_reg == S_SCAN) &&
                      ((req_reg != REQ_LIST) || !k_in || out_free);
    assign fin_go   = (state_reg == S_FIN) && !dist_busy;
    assign coord_bad = (coord_x > COORD_MAX) || (coord_y > COORD_MAX);
    assign dist_in_valid = step && k_in && (req_reg == REQ_QUERY);

    // ---------------------------------------------------------------- cell row
    assign ctl.rotate = step;
    assign ctl.shift  = fin_go && (req_reg == REQ_REMOVE) && found_reg;
    assign ctl.write  = fin_go && (req_reg == REQ_ADD) && !found_reg &&
                        (count_reg < CNT_W'(TABLE_DEPTH));
    assign ctl.key    = key;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        point_t nbr;
        logic   sel_shift;
        logic   sel_write;

        if (i < TABLE_DEPTH - 1)
        begin : g_mid
            assign nbr = cells[i+1];
        end
        else
        begin : g_top
            // top slot refills from the head on rotation, clears on removal
            assign nbr = ctl.rotate ? cells[0] : '0;
        end

        assign sel_shift = (IDX_W'(i) >= at_reg);
        assign sel_write = (CNT_W'(i) == count_reg);

        ptnq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .sel_shift (sel_shift),
            .sel_write (sel_write),
            .nbr_point (nbr),
            .point     (cells[i])
        );
    end

    ptnq_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dist_in_valid),
        .in_pt    (head),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .res      (dres),
        .busy     (dist_busy)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        qfound_next    = qfound_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        at_next        = at_reg;
        best_d_next    = best_d_reg;
        best_pt_next   = best_pt_reg;
        resp_st_next   = resp_st_reg;
        resp_pt_next   = resp_pt_reg;
        out_st_next    = out_st_reg;
        out_pt_next    = out_pt_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // nearest candidate: strict less keeps the earliest entry on a tie
        if (dres.valid && (!qfound_reg || (dres.sq_dist < best_d_reg)))
        begin
            qfound_next  = 1'b1;
            best_d_next  = dres.sq_dist;
            best_pt_next = dres.pt;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req_e'(req_type);
                    qx_next     = coord_x;
                    qy_next     = coord_y;
                    k_next      = '0;
                    found_next  = 1'b0;
                    qfound_next = 1'b0;
                    if ((req_e'(req_type) != REQ_LIST) && coord_bad)
                    begin
                        resp_st_next = ST_INVALID;
                        resp_pt_next = '0;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (step)
                begin
                    if (k_in && !found_reg && (head == key) &&
                        ((req_reg == REQ_ADD) || (req_reg == REQ_REMOVE)))
                    begin
                        found_next = 1'b1;
                        at_next    = k_reg;
                    end
                    if (k_in && (req_reg == REQ_LIST))
                    begin
                        out_valid_next = 1'b1;
                        out_st_next    = ST_LISTED;
                        out_pt_next    = head;
                        out_last_next  = (({1'b0, k_reg} + 1'b1) == count_reg);
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next   = S_RESP;
                    resp_pt_next = key;
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (found_reg)
                            begin
                                resp_st_next = ST_EXISTS;
                            end
                            else if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                resp_st_next = ST_FULL;
                                resp_pt_next = '0;
                            end
                            else
                            begin
                                resp_st_next = ST_ADDED;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                resp_st_next = ST_REMOVED;
                                count_next   = count_reg - 1'b1;
                            end
                            else
                            begin
                                resp_st_next = ST_ABSENT;
                            end
                        end
                        REQ_LIST:
                        begin
                            resp_st_next = ST_NONE;
                            resp_pt_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (qfound_reg)
                            begin
                                resp_st_next = ST_NEAREST;
                                resp_pt_next = best_pt_reg;
                            end
                            else
                            begin
                                resp_st_next = ST_NONE;
                                resp_pt_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = resp_st_reg;
                    out_pt_next    = resp_pt_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            qfound_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            qfound_reg    <= qfound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        at_reg       <= at_next;
        best_d_reg   <= best_d_next;
        best_pt_reg  <= best_pt_next;
        resp_st_reg  <= resp_st_next;
        resp_pt_reg  <= resp_pt_next;
        out_st_reg   <= out_st_next;
        out_pt_reg   <= out_pt_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign out_x     = out_pt_reg.x;
    assign out_y     = out_pt_reg.y;
    assign last      = out_last_reg;

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_FIN))
        else $error("entry count changed outside finish step");

    a_dist_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !dist_busy)
        else $error("distance pipeline busy while idle");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg == S_SCAN) || (state_reg == S_RESP)))
        else $error("accepted item did not start work");

endmodule

>>> tb/tb_point_table_nearest_query_core.sv
// tb_point_table_nearest_query_core: self-checking bench for the point table nearest query core.
// Depends on ptnq_pkg and point_table_nearest_query_core; drives random add, remove,
// list and query requests and checks every result item against a behavioral table.
`timescale 1ns / 1ps

module tb_point_table_nearest_query_core;
    import ptnq_pkg::*;

    // Run shape
    localparam int RANDOM_REQUESTS = 235;  // follows the directed rows
    localparam int MAX_GAP         = 19;   // per-item idle draw on either side
    localparam int HOLD_CYCLES     = 300;  // long result stall, fills the core up
    localparam int DRAIN_CYCLES    = 64;   // > one request after the last result
    localparam int WATCHDOG_LIMIT  = 2000; // cycles with no handshake on either side

    // One result item as the core presents it.
    typedef struct packed {
        status_e            st;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } answer_t;

    // Directed stimulus row. When fixed is set the single answer (last = 1) is typed in;
    // otherwise the answer comes from the table model below.
    typedef struct packed {
        req_e               req;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               fixed;
        status_e            st;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } dir_row_t;

    localparam int DIRECTED_COUNT = 25;
    localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty table right after reset
        '{REQ_LIST,   14'd0,     14'd0,     1'b1, ST_NONE,    14'd0,    14'd0},
        '{REQ_QUERY,  14'd100,   14'd200,   1'b1, ST_NONE,    14'd0,    14'd0},
        '{REQ_REMOVE, 14'd5,     14'd6,     1'b1, ST_ABSENT,  14'd5,    14'd6},
        // coordinates out of range, one just past the limit and the field maximum
        '{REQ_ADD,    14'd10000, 14'd0,     1'b1, ST_INVALID, 14'd0,    14'd0},
        '{REQ_ADD,    14'd0,     14'd16383, 1'b1, ST_INVALID, 14'd0,    14'd0},
        '{REQ_REMOVE, 14'd16383, 14'd16383, 1'b1, ST_INVALID, 14'd0,    14'd0},
        '{REQ_QUERY,  14'd9999,  14'd10000, 1'b1, ST_INVALID, 14'd0,    14'd0},
        // list does not look at the coordinates at all
        '{REQ_LIST,   14'd16383, 14'd16383, 1'b1, ST_NONE,    14'd0,    14'd0},
        // corners, duplicate add
        '{REQ_ADD,    14'd0,     14'd0,     1'b1, ST_ADDED,   14'd0,    14'd0},
        '{REQ_ADD,    14'd9999,  14'd9999,  1'b1, ST_ADDED,   14'd9999, 14'd9999},
        '{REQ_ADD,    14'd0,     14'd0,     1'b1, ST_EXISTS,  14'd0,    14'd0},
        '{REQ_ADD,    14'd9999,  14'd0,     1'b1, ST_ADDED,   14'd9999, 14'd0},
        '{REQ_ADD,    14'd2,     14'd0,     1'b1, ST_ADDED,   14'd2,    14'd0},
        '{REQ_LIST,   14'd16383, 14'd0,     1'b0, ST_INVALID, 14'd0,    14'd0},
        // exact hit, then a tie at distance 1 where the earlier entry wins
        '{REQ_QUERY,  14'd9999,  14'd9999,  1'b1, ST_NEAREST, 14'd9999, 14'd9999},
        '{REQ_QUERY,  14'd1,     14'd0,     1'b1, ST_NEAREST, 14'd0,    14'd0},
        '{REQ_QUERY,  14'd5000,  14'd5000,  1'b0, ST_INVALID, 14'd0,    14'd0},
        // remove from the middle, again (now absent), then first and last entries
        '{REQ_REMOVE, 14'd9999,  14'd9999,  1'b1, ST_REMOVED, 14'd9999, 14'd9999},
        '{REQ_REMOVE, 14'd9999,  14'd9999,  1'b1, ST_ABSENT,  14'd9999, 14'd9999},
        '{REQ_LIST,   14'd0,     14'd0,     1'b0, ST_INVALID, 14'd0,    14'd0},
        '{REQ_REMOVE, 14'd0,     14'd0,     1'b1, ST_REMOVED, 14'd0,    14'd0},
        '{REQ_REMOVE, 14'd2,     14'd0,     1'b1, ST_REMOVED, 14'd2,    14'd0},
        '{REQ_QUERY,  14'd0,     14'd9999,  1'b0, ST_INVALID, 14'd0,    14'd0},
        '{REQ_REMOVE, 14'd9999,  14'd0,     1'b1, ST_REMOVED, 14'd9999, 14'd0},
        '{REQ_LIST,   14'd0,     14'd0,     1'b1, ST_NONE,    14'd0,    14'd0}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type  = '0;
    logic [COORD_W-1:0] coord_x   = '0;
    logic [COORD_W-1:0] coord_y   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         status;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               last;

    // Table model: packed prefix of points, same order as the core keeps them.
    point_t  table_pts [TABLE_DEPTH];
    int      table_len = 0;
    answer_t expected_answers [$];

    bit growing = 1'b1;       // random phase bias: fill the table, or drain it
    int in_run  = 0;          // remaining no-idle items per side
    int out_run = 0;
    int errors           = 0;
    int requests_sent    = 0;
    int results_taken    = 0;
    int full_refusals    = 0;
    int points_listed    = 0;
    int idle_cycles      = 0;

    point_table_nearest_query_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_x     (out_x),
        .out_y     (out_y),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Idle cycles before the next item; now and then a run of back-to-back items.
    function automatic int draw_gap(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            run = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // In-range coordinate; a small cluster gives duplicates and distance ties.
    function automatic logic [COORD_W-1:0] valid_coord();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return COORD_W'($urandom_range(0, 7));
        if (roll == 3)
            return ($urandom_range(0, 1) == 1) ? COORD_MAX : '0;
        return COORD_W'($urandom_range(0, 9999));
    endfunction

    // Apply one accepted request to the table and queue the items it must produce.
    task automatic predict_request(input req_e r, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y, input bit fixed,
                                   input answer_t fixed_ans);
        answer_t           ans;
        point_t            key;
        int                at;
        int                best;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] best_d;
        key.x  = x;
        key.y  = y;
        ans.st   = ST_INVALID;
        ans.x    = '0;
        ans.y    = '0;
        ans.last = 1'b1;
        at     = -1;
        best   = -1;
        best_d = '0;
        for (int i = 0; i < table_len; i++)
            if (at < 0 && table_pts[i] == key)
                at = i;

        if (r == REQ_LIST)
        begin
            if (table_len == 0)
                ans.st = ST_NONE;
            else
            begin
                for (int i = 0; i < table_len; i++)
                begin
                    ans.st   = ST_LISTED;
                    ans.x    = table_pts[i].x;
                    ans.y    = table_pts[i].y;
                    ans.last = (i == table_len - 1);
                    expected_answers.push_back(ans);
                    points_listed++;
                end
                return;
            end
        end
        else if (x <= COORD_MAX && y <= COORD_MAX)
        begin
            case (r)
                REQ_ADD:
                begin
                    // a duplicate wins over a full table
                    if (at >= 0)
                    begin
                        ans.st = ST_EXISTS;
                        ans.x  = x;
                        ans.y  = y;
                    end
                    else if (table_len == TABLE_DEPTH)
                    begin
                        ans.st = ST_FULL;
                        full_refusals++;
                    end
                    else
                    begin
                        table_pts[table_len] = key;
                        table_len++;
                        ans.st = ST_ADDED;
                        ans.x  = x;
                        ans.y  = y;
                    end
                end
                REQ_REMOVE:
                begin
                    ans.x = x;
                    ans.y = y;
                    if (at < 0)
                        ans.st = ST_ABSENT;
                    else
                    begin
                        for (int i = at; i < table_len - 1; i++)
                            table_pts[i] = table_pts[i + 1];
                        table_pts[table_len - 1] = '0;
                        table_len--;
                        ans.st = ST_REMOVED;
                    end
                end
                default:
                begin
                    // squared distance, first entry wins a tie
                    for (int i = 0; i < table_len; i++)
                    begin
                        dx = (table_pts[i].x > x) ? table_pts[i].x - x : x - table_pts[i].x;
                        dy = (table_pts[i].y > y) ? table_pts[i].y - y : y - table_pts[i].y;
                        d  = dx * dx + dy * dy;
                        if (best < 0 || d < best_d)
                        begin
                            best   = i;
                            best_d = d;
                        end
                    end
                    if (best < 0)
                        ans.st = ST_NONE;
                    else
                    begin
                        ans.st = ST_NEAREST;
                        ans.x  = table_pts[best].x;
                        ans.y  = table_pts[best].y;
                    end
                end
            endcase
        end

        if (fixed)
            ans = fixed_ans;
        expected_answers.push_back(ans);
    endtask

    // Offer one request (entered and left just after a falling edge).
    task automatic send_request(input req_e r, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input bit fixed,
                                input answer_t fixed_ans);
        int gap;
        gap = draw_gap(in_run);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        coord_x  <= x;
        coord_y  <= y;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_request(r, x, y, fixed, fixed_ans);
        requests_sent++;
        @(negedge clk);
    endtask

    // Random request. Mostly well-formed traffic biased to fill the table up to the
    // full case and then drain it, with out-of-range coordinates mixed in.
    task automatic draw_request(output req_e r, output logic [COORD_W-1:0] x,
                                output logic [COORD_W-1:0] y);
        int     roll;
        int     add_hi;
        int     rem_hi;
        point_t stored;
        if (table_len == 0)
            growing = 1'b1;
        else if (table_len == TABLE_DEPTH && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        add_hi = growing ? 66 : 28;
        rem_hi = growing ? 76 : 66;
        stored = (table_len > 0) ? table_pts[$urandom_range(0, table_len - 1)] : '0;
        x      = valid_coord();
        y      = valid_coord();
        roll   = $urandom_range(0, 99);

        if (roll < 8)
        begin
            r = req_e'($urandom_range(0, 2));
            if (r == REQ_LIST)
                r = REQ_QUERY;
            x = COORD_W'($urandom_range(0, 16383));
            y = COORD_W'($urandom_range(0, 16383));
            case ($urandom_range(0, 2))
                0:       x = COORD_W'($urandom_range(10000, 16383));
                1:       y = COORD_W'($urandom_range(10000, 16383));
                default:
                begin
                    x = COORD_W'($urandom_range(10000, 16383));
                    y = COORD_W'($urandom_range(10000, 16383));
                end
            endcase
        end
        else if (roll < 16)
        begin
            r = REQ_LIST;
            x = COORD_W'($urandom_range(0, 16383));
            y = COORD_W'($urandom_range(0, 16383));
        end
        else if (roll < add_hi)
        begin
            r = REQ_ADD;
            if (table_len > 0 && $urandom_range(0, 4) == 0)
            begin
                x = stored.x;
                y = stored.y;
            end
        end
        else if (roll < rem_hi)
        begin
            r = REQ_REMOVE;
            if (table_len > 0 && $urandom_range(0, 9) < 7)
            begin
                x = stored.x;
                y = stored.y;
            end
        end
        else
        begin
            r = REQ_QUERY;
            if (table_len > 0 && $urandom_range(0, 4) == 0)
            begin
                x = stored.x;
                y = stored.y;
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endtask

    // Stimulus: reset, directed rows, random requests, then drain.
    initial
    begin : stimulus
        req_e               r;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        answer_t            fixed_ans;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            fixed_ans.st   = DIRECTED_ROWS[i].st;
            fixed_ans.x    = DIRECTED_ROWS[i].ex;
            fixed_ans.y    = DIRECTED_ROWS[i].ey;
            fixed_ans.last = 1'b1;
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y,
                         DIRECTED_ROWS[i].fixed, fixed_ans);
        end

        fixed_ans = '0;
        repeat (RANDOM_REQUESTS)
        begin
            draw_request(r, x, y);
            send_request(r, x, y, 1'b0, fixed_ans);
        end
        in_valid <= 1'b0;

        // the watchdog bounds this wait
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d result items, %0d points listed in order",
                 requests_sent, results_taken, points_listed);
        $display("%0d adds turned away by a full table, %0d mismatches",
                 full_refusals, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stalls per item, plus two long hold-offs so that the core
    // fills its output register and stops taking requests.
    initial
    begin : result_checker
        int      stall;
        answer_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (results_taken == 40 || results_taken == 180)
                stall = HOLD_CYCLES;
            else
                stall = draw_gap(out_run);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);

            results_taken++;
            if (expected_answers.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none expected: status %0d x %0d y %0d last %0d",
                         $time, status, out_x, out_y, last);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (status !== want.st)
                    report_field("status", want.st, status);
                if (out_x !== want.x)
                    report_field("out_x", want.x, out_x);
                if (out_y !== want.y)
                    report_field("out_y", want.y, out_y);
                if (last !== want.last)
                    report_field("last", want.last, last);
            end
        end
    end

    // Watchdog: no handshake on either side for too long means the core is stuck.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d result items still owed",
                     $time, idle_cycles, expected_answers.size());
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
